// ----- src/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types, codes and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int KIND_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int CELL_ADDR_W = 11;
    localparam int CELL_W      = 16;
    localparam int CUR_ROW_W   = 5;
    localparam int CUR_COL_W   = 7;
    localparam int COLOR_W     = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = COLOR_W;

    localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0]  CH_BLANK     = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_FG     = 4'hF;
    localparam logic [COLOR_W-1:0] RESET_BG     = 4'h0;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOREGROUND = 1'b0,
        REG_BACKGROUND = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SCROLL,
        ST_READ,
        ST_DONE
    } t_state;

    function automatic logic [CELL_W-1:0] make_cell(
        input logic [COLOR_W-1:0] bg,
        input logic [COLOR_W-1:0] fg,
        input logic [CHAR_W-1:0]  ch
    );
        return {bg, fg, ch};
    endfunction

    localparam logic [CELL_W-1:0] RESET_BLANK = make_cell(RESET_BG, RESET_FG, CH_BLANK);

endpackage

// ----- src/tcce_in_if.sv -----
// ----------------------------------------------------------------------------
// tcce_in_if
// Command channel: item kind, character byte and cell address.
// ----------------------------------------------------------------------------
interface tcce_in_if;
    import tcce_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [KIND_W-1:0]      kind;
    logic [CHAR_W-1:0]      char_code;
    logic [CELL_ADDR_W-1:0] cell_address;

    modport source (output valid, kind, char_code, cell_address, input ready);
    modport sink   (input valid, kind, char_code, cell_address, output ready);
endinterface

// ----- src/tcce_out_if.sv -----
// ----------------------------------------------------------------------------
// tcce_out_if
// Result channel: cell word and cursor position after each command.
// ----------------------------------------------------------------------------
interface tcce_out_if;
    import tcce_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    cell_data;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [CUR_COL_W-1:0] cursor_col;

    modport source (output valid, cell_data, cursor_row, cursor_col, input ready);
    modport sink   (input valid, cell_data, cursor_row, cursor_col, output ready);
endinterface

// ----- src/tcce_store.sv -----
// ----------------------------------------------------------------------------
// tcce_store
// Screen cell memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcce_store #(
    parameter int DEPTH = tcce_pkg::DEF_COLUMNS * tcce_pkg::DEF_ROWS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [tcce_pkg::CELL_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [tcce_pkg::CELL_W-1:0] o_rdata
);
    import tcce_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/tcce_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcce_ctrl
// Command sequencer: cursor, colors, fill/scroll sweeps and result register.
// ----------------------------------------------------------------------------
module tcce_ctrl #(
    parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcce_pkg::DEF_ROWS,
    parameter int AW      = $clog2(COLUMNS * ROWS)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tcce_in_if.sink                         i_in,
    tcce_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tcce_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_mem_we,
    output logic [AW-1:0]                   o_mem_waddr,
    output logic [tcce_pkg::CELL_W-1:0]     o_mem_wdata,
    output logic [AW-1:0]                   o_mem_raddr,
    input  logic [tcce_pkg::CELL_W-1:0]     i_mem_rdata
);
    import tcce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int CMP_W = (CNT_W > CELL_ADDR_W) ? CNT_W : CELL_ADDR_W;

    localparam logic [COL_W-1:0] LAST_COL   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [AW-1:0]    ROW_STEP   = AW'(COLUMNS);
    localparam logic [CNT_W-1:0] CELLS_C    = CNT_W'(CELLS);
    localparam logic [CNT_W-1:0] SCROLL_SRC = CNT_W'(COLUMNS);
    localparam logic [CNT_W-1:0] BOTTOM_ROW = CNT_W'(CELLS - COLUMNS);
    localparam logic [CNT_W-1:0] LAST_CELL  = CNT_W'(CELLS - 1);
    localparam logic [CMP_W-1:0] CELLS_CMP  = CMP_W'(CELLS);

    t_state               r_state, n_state;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [COL_W-1:0]     r_col, n_col;
    logic [AW-1:0]        r_base, n_base;
    logic [CNT_W-1:0]     r_ptr, n_ptr;
    logic                 r_pend, n_pend;
    logic [AW-1:0]        r_wa, n_wa;
    logic [CELL_W-1:0]    r_fill, n_fill;
    logic                 r_init, n_init;
    logic                 r_zero, n_zero;
    logic [CELL_W-1:0]    r_data, n_data;
    logic                 r_ovalid, n_ovalid;
    logic [CELL_W-1:0]    r_odata, n_odata;
    logic [CUR_ROW_W-1:0] r_orow, n_orow;
    logic [CUR_COL_W-1:0] r_ocol, n_ocol;
    logic [COLOR_W-1:0]   r_fg, r_bg;

    logic                 in_ready;
    logic                 adv;
    logic [COL_W-1:0]     bs_col;
    logic [CELL_W-1:0]    blank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= RESET_FG;
            r_bg <= RESET_BG;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_FOREGROUND: r_fg <= i_cfg_data;
                REG_BACKGROUND: r_bg <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_FILL;
            r_row    <= '0;
            r_col    <= '0;
            r_base   <= '0;
            r_ptr    <= '0;
            r_pend   <= 1'b0;
            r_fill   <= RESET_BLANK;
            r_init   <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_base   <= n_base;
            r_ptr    <= n_ptr;
            r_pend   <= n_pend;
            r_fill   <= n_fill;
            r_init   <= n_init;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa    <= n_wa;
        r_zero  <= n_zero;
        r_data  <= n_data;
        r_odata <= n_odata;
        r_orow  <= n_orow;
        r_ocol  <= n_ocol;
    end

    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_col    = r_col;
        n_base   = r_base;
        n_ptr    = r_ptr;
        n_pend   = r_pend;
        n_wa     = r_wa;
        n_fill   = r_fill;
        n_init   = r_init;
        n_zero   = r_zero;
        n_data   = r_data;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        n_orow   = r_orow;
        n_ocol   = r_ocol;

        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_raddr = '0;

        in_ready = (r_state == ST_IDLE);
        adv      = 1'b0;
        bs_col   = (r_col != '0) ? r_col - 1'b1 : r_col;
        blank    = make_cell(r_bg, r_fg, CH_BLANK);

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_data  = '0;
                    n_state = ST_DONE;
                    case (i_in.kind)
                        KIND_PUT: begin
                            case (i_in.char_code)
                                CH_NEWLINE: begin
                                    n_col = '0;
                                    adv   = 1'b1;
                                end
                                CH_RETURN: begin
                                    n_col = '0;
                                end
                                CH_BACKSPACE: begin
                                    n_col       = bs_col;
                                    o_mem_we    = 1'b1;
                                    o_mem_waddr = AW'(r_base + AW'(bs_col));
                                    o_mem_wdata = blank;
                                end
                                default: begin
                                    o_mem_we    = 1'b1;
                                    o_mem_waddr = AW'(r_base + AW'(r_col));
                                    o_mem_wdata = make_cell(r_bg, r_fg, i_in.char_code);
                                    if (r_col == LAST_COL) begin
                                        n_col = '0;
                                        adv   = 1'b1;
                                    end else begin
                                        n_col = r_col + 1'b1;
                                    end
                                end
                            endcase
                            if (adv) begin
                                if (r_row == LAST_ROW) begin
                                    n_ptr   = SCROLL_SRC;
                                    n_pend  = 1'b0;
                                    n_state = ST_SCROLL;
                                end else begin
                                    n_row  = r_row + 1'b1;
                                    n_base = AW'(r_base + ROW_STEP);
                                end
                            end
                        end
                        KIND_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_base  = '0;
                            n_ptr   = '0;
                            n_fill  = blank;
                            n_init  = 1'b0;
                            n_state = ST_FILL;
                        end
                        KIND_READ: begin
                            o_mem_raddr = AW'(i_in.cell_address);
                            n_zero      = !(CMP_W'(i_in.cell_address) < CELLS_CMP);
                            n_state     = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCROLL: begin
                // read one row ahead, write the previous read back one row up
                if (r_pend) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_wa;
                    o_mem_wdata = i_mem_rdata;
                end
                if (r_ptr != CELLS_C) begin
                    o_mem_raddr = r_ptr[AW-1:0];
                    n_pend      = 1'b1;
                    n_wa        = AW'(r_ptr - SCROLL_SRC);
                    n_ptr       = r_ptr + 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_ptr   = BOTTOM_ROW;
                    n_fill  = blank;
                    n_init  = 1'b0;
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr[AW-1:0];
                o_mem_wdata = r_fill;
                n_ptr       = r_ptr + 1'b1;
                if (r_ptr == LAST_CELL) begin
                    n_init  = 1'b0;
                    n_state = r_init ? ST_IDLE : ST_DONE;
                end
            end
            ST_READ: begin
                n_data  = r_zero ? '0 : i_mem_rdata;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_data;
                    n_orow   = CUR_ROW_W'(r_row);
                    n_ocol   = CUR_COL_W'(r_col);
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_ovalid;
    assign o_out.cell_data  = r_odata;
    assign o_out.cursor_row = r_orow;
    assign o_out.cursor_col = r_ocol;

endmodule

// ----- src/text_console_cursor_engine_top.sv -----
// Sequence: put character, return, newline, backspace and unused kind go to a done
//   state that registers the result; a cell read first passes a read state (memory read port).
// Clear sweeps the store one cell per cycle, then gives its result.
// A scroll copies the store up one row, then blanks the bottom row.
// Throughput: one command at a time; the next is taken when the sequencer is idle.
// Reset: synchronous; a blanking pass over every cell runs before input is taken.
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top
// Text console with a screen cell store, cursor and scroll/clear sequencer.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_top #(
    parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tcce_in_if.sink                         i_in,
    tcce_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tcce_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tcce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    tcce_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    tcce_store #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

// ----- src/tcce_checker.sv -----
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks of the console engine, bound to the top level.
// ----------------------------------------------------------------------------
module tcce_checker #(
    parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [tcce_pkg::CELL_W-1:0]    i_cell_data,
    input logic [tcce_pkg::CUR_ROW_W-1:0] i_cursor_row,
    input logic [tcce_pkg::CUR_COL_W-1:0] i_cursor_col
);
    import tcce_pkg::*;

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_cursor_row) < ROWS))
        else $error("cursor row out of range");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_cursor_col) < COLUMNS))
        else $error("cursor column out of range");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken again before the command finished");

    a_blank_pass: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_in_ready)
        else $error("input taken during the reset blanking pass");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_cell_data)))
        else $error("stalled result changed");

endmodule

bind text_console_cursor_engine_top tcce_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcce_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_cell_data  (o_out.cell_data),
    .i_cursor_row (o_out.cursor_row),
    .i_cursor_col (o_out.cursor_col)
);

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console cursor engine. A queue-fed driver
// sends put, clear, read and spare commands; a monitor runs a shadow screen
// and cursor on every accepted command and compares each result transfer
// field by field. Colors change between phases while the engine is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import tcce_pkg::*;

    localparam int COLS        = DEF_COLUMNS;
    localparam int ROWS        = DEF_ROWS;
    localparam int CELLS       = COLS * ROWS;
    localparam int QUIET_LIMIT = 20000;
    localparam int LONG_HOLD   = 400;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [CHAR_W-1:0]      ch;
        logic [CELL_ADDR_W-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic [CELL_W-1:0]    data;
        logic [CUR_ROW_W-1:0] row;
        logic [CUR_COL_W-1:0] col;
    } t_reply;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    tcce_in_if  cmd_if ();
    tcce_out_if rsp_if ();

    text_console_cursor_engine_top #(
        .COLUMNS (COLS),
        .ROWS    (ROWS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (cmd_if),
        .o_out      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // shadow console
    logic [CELL_W-1:0]  screen_m [0:CELLS-1];
    int unsigned        row_m;
    int unsigned        col_m;
    logic [COLOR_W-1:0] fg_m;
    logic [COLOR_W-1:0] bg_m;

    t_cmd   command_q [$];
    t_reply cursor_reply_q [$];
    int unsigned cmds_queued;
    int unsigned replies_seen;
    int unsigned failures;
    int unsigned quiet_cycles;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned hold_left;
    bit          cmd_taken;
    bit          calm;
    bit          long_hold_req;

    always #5 i_clk = ~i_clk;

    function automatic logic [CELL_W-1:0] tinted(logic [CHAR_W-1:0] ch);
        return {bg_m, fg_m, ch};
    endfunction

    function automatic t_reply console_apply(t_cmd c);
        t_reply r;
        r.data = '0;
        case (c.kind)
            KIND_PUT: begin
                if (c.ch == CH_NEWLINE) begin
                    col_m = 0;
                    row_m++;
                end else if (c.ch == CH_RETURN) begin
                    col_m = 0;
                end else if (c.ch == CH_BACKSPACE) begin
                    if (col_m > 0) col_m--;
                    screen_m[row_m * COLS + col_m] = tinted(CH_BLANK);
                end else begin
                    screen_m[row_m * COLS + col_m] = tinted(c.ch);
                    col_m++;
                end
                if (col_m >= COLS) begin
                    col_m = 0;
                    row_m++;
                end
                if (row_m >= ROWS) begin
                    for (int i = 0; i + COLS < CELLS; i++) screen_m[i] = screen_m[i + COLS];
                    for (int i = CELLS - COLS; i < CELLS; i++) screen_m[i] = tinted(CH_BLANK);
                    row_m = ROWS - 1;
                end
            end
            KIND_CLEAR: begin
                for (int i = 0; i < CELLS; i++) screen_m[i] = tinted(CH_BLANK);
                row_m = 0;
                col_m = 0;
            end
            KIND_READ: begin
                if (c.addr < CELLS) r.data = screen_m[c.addr];
            end
            default: ;
        endcase
        r.row = row_m[CUR_ROW_W-1:0];
        r.col = col_m[CUR_COL_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            failures++;
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endfunction

    task automatic push_cmd(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch,
                            logic [CELL_ADDR_W-1:0] addr);
        t_cmd c;
        c.kind = kind;
        c.ch   = ch;
        c.addr = addr;
        command_q.push_back(c);
        cmds_queued++;
    endtask

    task automatic queue_mixed_cmd();
        int unsigned pick;
        int unsigned spot;
        logic [CHAR_W-1:0]      ch;
        logic [CELL_ADDR_W-1:0] addr;
        pick = $urandom_range(0, 99);
        spot = $urandom_range(0, 9);
        ch   = CHAR_W'($urandom_range(0, 255));
        addr = CELL_ADDR_W'($urandom_range(0, 2047));
        if (pick < 52) begin
            push_cmd(KIND_PUT, ch, addr);
        end else if (pick < 66) begin
            push_cmd(KIND_PUT, CH_NEWLINE, addr);
        end else if (pick < 71) begin
            push_cmd(KIND_PUT, CH_RETURN, addr);
        end else if (pick < 78) begin
            push_cmd(KIND_PUT, CH_BACKSPACE, addr);
        end else if (pick < 94) begin
            if (spot < 5) addr = CELL_ADDR_W'($urandom_range(0, CELLS - 1));
            else if (spot < 8) addr = CELL_ADDR_W'($urandom_range((ROWS - 2) * COLS, CELLS - 1));
            else addr = CELL_ADDR_W'($urandom_range(CELLS, 2047));
            push_cmd(KIND_READ, ch, addr);
        end else if (pick < 97) begin
            push_cmd(KIND_CLEAR, ch, addr);
        end else begin
            push_cmd(KIND_SPARE, ch, addr);
        end
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [COLOR_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == REG_FOREGROUND) fg_m = val;
        else bg_m = val;
    endtask

    task automatic wait_idle();
        while (replies_seen != cmds_queued) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // command driver
    always @(negedge i_clk) begin
        t_cmd next_cmd;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_taken) begin
            cmd_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                cmd_if.valid <= 1'b0;
            end else if (command_q.size() != 0) begin
                next_cmd = command_q.pop_front();
                cmd_if.valid        <= 1'b1;
                cmd_if.kind         <= next_cmd.kind;
                cmd_if.char_code    <= next_cmd.ch;
                cmd_if.cell_address <= next_cmd.addr;
                if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 14);
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
        end
    end

    // monitor: check result transfers, predict on command transfers
    always @(posedge i_clk) begin
        t_reply want;
        t_cmd   taken;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (cursor_reply_q.size() == 0) begin
                    failures++;
                    $display("%0t: result transfer with no command outstanding", $time);
                end else begin
                    want = cursor_reply_q.pop_front();
                    replies_seen++;
                    check_field("cell_data", want.data, rsp_if.cell_data);
                    check_field("cursor_row", want.row, rsp_if.cursor_row);
                    check_field("cursor_col", want.col, rsp_if.cursor_col);
                end
            end
            if (cmd_if.valid && cmd_if.ready) begin
                taken.kind = cmd_if.kind;
                taken.ch   = cmd_if.char_code;
                taken.addr = cmd_if.cell_address;
                cursor_reply_q.push_back(console_apply(taken));
                cmd_taken = 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("text_console_cursor_engine_top verification failed");
            $finish;
        end
    end

    initial begin
        logic [COLOR_W-1:0] fg_set;
        logic [COLOR_W-1:0] bg_set;
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = REG_FOREGROUND;
        cfg_data            = '0;
        cmd_if.valid        = 1'b0;
        cmd_if.kind         = KIND_PUT;
        cmd_if.char_code    = '0;
        cmd_if.cell_address = '0;
        rsp_if.ready        = 1'b0;
        cmds_queued   = 0;
        replies_seen  = 0;
        failures      = 0;
        quiet_cycles  = 0;
        send_gap      = 0;
        stall_left    = 0;
        hold_left     = 0;
        cmd_taken     = 1'b0;
        calm          = 1'b0;
        long_hold_req = 1'b0;
        fg_m  = RESET_FG;
        bg_m  = RESET_BG;
        row_m = 0;
        col_m = 0;
        for (int i = 0; i < CELLS; i++) screen_m[i] = tinted(CH_BLANK);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            case (ph)
                0: begin fg_set = 4'hF; bg_set = 4'h0; end
                1: begin fg_set = 4'h0; bg_set = 4'hF; end
                2: begin
                    fg_set = COLOR_W'($urandom_range(0, 15));
                    bg_set = COLOR_W'($urandom_range(0, 15));
                end
                default: begin fg_set = 4'hF; bg_set = 4'hF; end
            endcase
            write_reg(REG_FOREGROUND, fg_set);
            write_reg(REG_BACKGROUND, bg_set);
            calm = (ph == 3);

            if (ph == 0) begin
                push_cmd(KIND_READ, 8'h00, 11'd0);
                push_cmd(KIND_READ, 8'hFF, 11'(CELLS - 1));
                push_cmd(KIND_READ, 8'h00, 11'(CELLS));
                push_cmd(KIND_READ, 8'h00, 11'h7FF);
                push_cmd(KIND_PUT, 8'h41, 11'd0);
                push_cmd(KIND_PUT, 8'hFF, 11'h7FF);
                push_cmd(KIND_PUT, 8'h00, 11'd0);
                push_cmd(KIND_PUT, 8'h55, 11'h2AA);
                push_cmd(KIND_PUT, 8'hAA, 11'h555);
                push_cmd(KIND_READ, 8'h00, 11'd1);
                push_cmd(KIND_PUT, CH_BACKSPACE, 11'd0);
                push_cmd(KIND_READ, 8'h00, 11'd4);
                push_cmd(KIND_PUT, CH_RETURN, 11'd0);
                push_cmd(KIND_PUT, CH_BACKSPACE, 11'd0);
                push_cmd(KIND_READ, 8'h00, 11'd0);
                push_cmd(KIND_PUT, CH_NEWLINE, 11'd0);
                push_cmd(KIND_SPARE, 8'hFF, 11'h7FF);
                push_cmd(KIND_PUT, 8'h7E, 11'd0);
                push_cmd(KIND_READ, 8'h00, 11'(COLS));
                push_cmd(KIND_CLEAR, 8'h00, 11'd0);
                push_cmd(KIND_READ, 8'h00, 11'd2);
                push_cmd(KIND_SPARE, 8'h00, 11'd0);
            end

            if (ph == 1) begin
                @(posedge i_clk);
                long_hold_req = 1'b1;
            end

            // newline runs force a scroll; long lines of random characters may force a column wrap
            if (ph % 2 == 0) begin
                repeat ($urandom_range(25, 28))
                    push_cmd(KIND_PUT, CH_NEWLINE, CELL_ADDR_W'($urandom_range(0, 2047)));
            end else begin
                repeat ($urandom_range(78, 84))
                    push_cmd(KIND_PUT, CHAR_W'($urandom_range(0, 255)),
                             CELL_ADDR_W'($urandom_range(0, 2047)));
                push_cmd(KIND_READ, 8'h00, 11'($urandom_range((ROWS - 2) * COLS, CELLS - 1)));
            end
            repeat (25) queue_mixed_cmd();
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (failures == 0 && cursor_reply_q.size() == 0) begin
            $display("text_console_cursor_engine_top verification clean");
        end else begin
            $display("text_console_cursor_engine_top verification failed");
        end
        $finish;
    end

endmodule
